@@ hw/rtl/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 digest unit.
`default_nettype none
package sha1_pkg;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LENGTH_FIELD_BITS = 64;
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic flush;     // this byte closes the message; emit the digest after it
    } qbeat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        FS_TAKE,
        FS_PAD,
        FS_LEN
    } front_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/sha1_message_digest_unit.sv @@
// SHA-1 digest unit top level: front end, beat queue and compression core.
// Takes one message byte per beat; the last byte carries final_byte. Bytes
// flow through a four-entry queue to the core, which takes one byte per cycle
// and then holds off while it runs the 80 rounds and the add step of each
// 64-byte block. After the final byte the front end generates the padding
// and length bytes itself (9 to 72 bytes, which may spill into a second
// block), after which the core emits the digest. The five digest words
// leave as five beats with word_index 0 to 4 and last_word on the fifth.
`default_nettype none
module sha1_message_digest_unit
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    logic fq_valid, fq_stall, qc_valid, qc_stall;
    qbeat_t fq_beat, qc_beat;

    sha1_front u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .data_byte, .final_byte,
        .q_valid(fq_valid), .q_beat(fq_beat), .q_stall(fq_stall)
    );
    sha1_queue u_queue (
        .clk, .rst_n, .in_valid(fq_valid), .in_beat(fq_beat), .in_stall(fq_stall),
        .out_valid(qc_valid), .out_beat(qc_beat), .out_stall(qc_stall)
    );
    sha1_core u_core (
        .clk, .rst_n, .q_valid(qc_valid), .q_beat(qc_beat), .q_stall(qc_stall),
        .valid(out_valid), .stall(out_stall), .digest_word, .word_index, .last_word
    );

    a_last_on_four: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)))
        else $error("last_word does not match word_index");
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=> (out_valid &&
        word_index == $past(word_index) + 3'd1))
        else $error("digest words not delivered in order");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (word_index <= 3'd4))
        else $error("word_index out of range");
endmodule
`default_nettype wire

@@ hw/rtl/sha1_front.sv @@
// Front end: takes message bytes and generates padding and length bytes.
`default_nettype none
module sha1_front
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             q_valid,
    output qbeat_t           q_beat,
    input  wire logic        q_stall
);
    front_state_t state_reg, state_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0] pos_reg, pos_next;
    logic [2:0] lenidx_reg, lenidx_next;
    logic [63:0] len;
    logic push;

    assign len = (LENGTH_FIELD_BITS == 64) ? bits_reg
               : (bits_reg & ((64'd1 << LENGTH_FIELD_BITS) - 64'd1));

    always_comb
    begin
        stall = (state_reg != FS_TAKE) || q_stall;
        q_valid = (state_reg == FS_TAKE) ? valid : 1'b1;
        q_beat.flush = 1'b0;
        unique case (state_reg)
            FS_TAKE: q_beat.data = data_byte;
            FS_PAD:  q_beat.data = 8'h00;
            FS_LEN:
            begin
                q_beat.data = len[8'(7 - lenidx_reg) * 8 +: 8];
                q_beat.flush = (lenidx_reg == 3'd7);
            end
            default: q_beat.data = 8'h00;
        endcase
        if (state_reg == FS_PAD && bits_reg[1])
            q_beat.data = PAD_BYTE;
    end

    // bits_reg[1] marks that the 0x80 byte is still owed (bit count is a multiple of 8).
    always_comb
    begin
        push = q_valid && !q_stall;
        state_next = state_reg;
        bits_next = bits_reg;
        pos_next = push ? pos_reg + 6'd1 : pos_reg;
        lenidx_next = lenidx_reg;
        unique case (state_reg)
            FS_TAKE:
                if (push)
                begin
                    bits_next = bits_reg + 64'd8;
                    if (final_byte)
                    begin
                        state_next = FS_PAD;
                        bits_next[1] = 1'b1;
                    end
                end
            FS_PAD:
                if (push)
                begin
                    bits_next[1] = 1'b0;
                    if (pos_reg == 6'd55)
                        state_next = FS_LEN;
                end
            FS_LEN:
                if (push)
                begin
                    lenidx_next = lenidx_reg + 3'd1;
                    if (lenidx_reg == 3'd7)
                    begin
                        state_next = FS_TAKE;
                        bits_next = '0;
                    end
                end
            default: state_next = FS_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_TAKE;
            bits_reg <= '0;
            pos_reg <= '0;
            lenidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg <= bits_next;
            pos_reg <= pos_next;
            lenidx_reg <= lenidx_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha1_queue.sv @@
// Short FIFO between the front end and the compression core.
`default_nettype none
module sha1_queue
    import sha1_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire qbeat_t in_beat,
    output logic        in_stall,
    output logic        out_valid,
    output qbeat_t      out_beat,
    input  wire logic   out_stall
);
    localparam int AW = $clog2(QDEPTH);
    qbeat_t mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic wr, rd;

    assign in_stall = (cnt_reg == (AW+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_beat = mem_reg[rp_reg];
    assign wr = in_valid && !in_stall;
    assign rd = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + AW'(1);
            if (rd)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha1_core.sv @@
// Back end: packs bytes into words, runs 80 rounds per block, emits the digest.
`default_nettype none
module sha1_core
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire qbeat_t      q_beat,
    output logic             q_stall,
    output logic             valid,
    input  wire logic        stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    back_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0] pos_reg;
    logic [6:0] rnd_reg;
    logic [2:0] idx_reg;
    logic flush_reg;
    logic take, rnd_last;
    logic [31:0] wt, f, k, tmp;

    assign take = q_valid && (state_reg == ST_IDLE);
    assign q_stall = (state_reg != ST_IDLE);
    assign rnd_last = (rnd_reg == 7'd79);
    assign valid = (state_reg == ST_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index = idx_reg;
    assign last_word = (idx_reg == 3'd4);

    always_comb
    begin
        logic [31:0] x;
        x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wt = (rnd_reg < 7'd16) ? w_reg[0] : {x[30:0], x[31]};
        priority if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (take && pos_reg == 6'd63)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_last)
                    state_next = ST_ADD;
            ST_ADD:
                state_next = flush_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (!stall && idx_reg == 3'd4)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // The 16 schedule words shift through w_reg; the word in use sits at index 0.
    // A finished word moves down when the first byte of the next one arrives.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (pos_reg[1:0] == 2'd0)
                w_reg[15] <= {q_beat.data, 24'h0};
            else
                w_reg[15][8'(3 - pos_reg[1:0]) * 8 +: 8] <= q_beat.data;
            if (pos_reg[1:0] == 2'd0 && pos_reg != 6'd0)
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
        end
        if (take && pos_reg == 6'd63)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg[0] <= IV0;
            h_reg[1] <= IV1;
            h_reg[2] <= IV2;
            h_reg[3] <= IV3;
            h_reg[4] <= IV4;
            pos_reg <= '0;
            rnd_reg <= '0;
            idx_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                pos_reg <= pos_reg + 6'd1;
                flush_reg <= q_beat.flush;
            end
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_last ? 7'd0 : rnd_reg + 7'd1;
            if (state_reg == ST_ADD)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (state_reg == ST_EMIT && !stall)
            begin
                if (idx_reg == 3'd4)
                begin
                    idx_reg <= '0;
                    h_reg[0] <= IV0;
                    h_reg[1] <= IV1;
                    h_reg[2] <= IV2;
                    h_reg[3] <= IV3;
                    h_reg[4] <= IV4;
                end
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end
endmodule
`default_nettype wire
